[src/cpu_alu_with_flags_unit_assert.svh]
// ----------------------------------------------------------------------------
// cpu_alu_with_flags_unit_assert.svh
// Assertion macros shared by the ALU unit.
// ----------------------------------------------------------------------------
`ifndef CPU_ALU_WITH_FLAGS_UNIT_ASSERT_SVH
`define CPU_ALU_WITH_FLAGS_UNIT_ASSERT_SVH

// Check a property outside reset.
`define CALU_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define CALU_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/calu_pkg.sv]
// ----------------------------------------------------------------------------
// calu_pkg
// Opcodes, flag layout, constants and item types of the ALU unit.
// ----------------------------------------------------------------------------
package calu_pkg;

    localparam int OP_W    = 5;
    localparam int WORD_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int BIDX_W  = 3;
    localparam int FLAGS_W = 4;

    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    localparam logic [FLAGS_W-1:0] FLAGS_RESET = 4'b1011;

    localparam logic [OP_W-1:0] OP_ADD    = 5'd0;
    localparam logic [OP_W-1:0] OP_ADC    = 5'd1;
    localparam logic [OP_W-1:0] OP_SUB    = 5'd2;
    localparam logic [OP_W-1:0] OP_SBC    = 5'd3;
    localparam logic [OP_W-1:0] OP_AND    = 5'd4;
    localparam logic [OP_W-1:0] OP_OR     = 5'd5;
    localparam logic [OP_W-1:0] OP_XOR    = 5'd6;
    localparam logic [OP_W-1:0] OP_INC    = 5'd7;
    localparam logic [OP_W-1:0] OP_DEC    = 5'd8;
    localparam logic [OP_W-1:0] OP_ADD16  = 5'd9;
    localparam logic [OP_W-1:0] OP_ADDSP  = 5'd10;
    localparam logic [OP_W-1:0] OP_SWAP   = 5'd11;
    localparam logic [OP_W-1:0] OP_RL     = 5'd12;
    localparam logic [OP_W-1:0] OP_RLC    = 5'd13;
    localparam logic [OP_W-1:0] OP_RR     = 5'd14;
    localparam logic [OP_W-1:0] OP_RRC    = 5'd15;
    localparam logic [OP_W-1:0] OP_SLA    = 5'd16;
    localparam logic [OP_W-1:0] OP_SRA    = 5'd17;
    localparam logic [OP_W-1:0] OP_SRL    = 5'd18;
    localparam logic [OP_W-1:0] OP_BIT    = 5'd19;
    localparam logic [OP_W-1:0] OP_SET    = 5'd20;
    localparam logic [OP_W-1:0] OP_RES    = 5'd21;
    localparam logic [OP_W-1:0] OP_DAA    = 5'd22;

    localparam logic [BYTE_W-1:0] DAA_ADJ_LO   = 8'h06;
    localparam logic [BYTE_W-1:0] DAA_ADJ_HI   = 8'h60;
    localparam logic [BYTE_W-1:0] DAA_ADJ_BOTH = 8'h66;
    localparam logic [BYTE_W-1:0] DAA_BCD_MAX  = 8'h99;
    localparam logic [3:0]        DAA_DIGIT_MAX = 4'h9;

    typedef struct packed {
        logic [BIDX_W-1:0] bit_index;
        logic [WORD_W-1:0] operand_b;
        logic [WORD_W-1:0] operand_a;
        logic [OP_W-1:0]   op;
    } alu_item_t;

    typedef struct packed {
        logic [FLAGS_W-1:0] flags;
        logic [WORD_W-1:0]  result;
    } alu_res_t;

endpackage

[src/cpu_alu_with_flags_unit.sv]
// ----------------------------------------------------------------------------
// cpu_alu_with_flags_unit
// 8-bit CPU ALU with a kept Z/N/H/C flag register and decimal adjust.
// ----------------------------------------------------------------------------
// Usage:
//   The s_* channel carries one operation per transfer: opcode, two 16-bit
//   operands and a bit index. The m_* channel returns one transfer per
//   operation with the result and the new flags, in issue order.
//   The input register takes each transfer, and the ALU logic then loads
//   the result register, which drives m_tvalid.
//   Throughput is one operation per cycle while m_tready stays high; the
//   flag register feeds the next operation straight from the ALU stage, so
//   dependent operations issue back to back.
//   Reset clears both pipeline stages and loads the flags with Z, H and C
//   set. When the receiver holds m_tready low the result register holds,
//   the input register fills, and s_tready drops only when both are full.
//   s_tready depends on m_tready within the same cycle.
// ----------------------------------------------------------------------------
`include "cpu_alu_with_flags_unit_assert.svh"

module cpu_alu_with_flags_unit
    import calu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // op[4:0], operand_a[20:5], operand_b[36:21], bit_index[39:37]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // result[15:0], flags[19:16], zero[23:20]
);

    logic               in_valid_reg;
    alu_item_t          in_item_reg;
    logic               out_valid_reg;
    alu_res_t           out_res_reg;
    logic [FLAGS_W-1:0] flag_reg;
    alu_res_t           alu_next;
    logic               advance;
    logic               in_load;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_load  = s_tvalid && s_tready;

    calu_core u_core (
        .item     (in_item_reg),
        .flags_in (flag_reg),
        .res      (alu_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flag_reg      <= FLAGS_RESET;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                flag_reg      <= alu_next.flags;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_item_reg <= alu_item_t'(s_tdata);
        end
        if (advance)
        begin
            out_res_reg <= alu_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_res_reg};

    `CALU_ASSERT_ALWAYS(a_flags_reset, !rst_n |=> flag_reg == FLAGS_RESET, "flags not at reset value")
    `CALU_ASSERT(a_flags_hold, !advance |=> $stable(flag_reg), "flags changed without an operation")
    `CALU_ASSERT(a_flags_out, advance |=> m_tvalid && m_tdata[19:16] == flag_reg, "output flags differ from flag register")
    `CALU_ASSERT(a_item_kept, in_valid_reg && !advance |=> in_valid_reg, "pending operation dropped")

endmodule

[src/calu_core.sv]
// ----------------------------------------------------------------------------
// calu_core
// Combinational ALU datapath: result and new flags from one item.
// ----------------------------------------------------------------------------
module calu_core
    import calu_pkg::*;
(
    input  alu_item_t          item,
    input  logic [FLAGS_W-1:0] flags_in,
    output alu_res_t           res
);

    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic              cin;
    logic              t;
    logic [BYTE_W:0]   sum9;
    logic [4:0]        nib_sum;
    logic [BYTE_W:0]   dif9;
    logic [4:0]        nib_dif;
    logic [BYTE_W-1:0] inc8;
    logic [BYTE_W-1:0] dec8;
    logic [WORD_W:0]   sum17;
    logic [12:0]       sum13;
    logic [WORD_W-1:0] b_sext;
    logic [BYTE_W:0]   sp_c9;
    logic [4:0]        sp_h5;
    logic [BYTE_W-1:0] mask8;
    logic              lo_big;
    logic [BYTE_W-1:0] daa_r;
    logic              daa_c;
    logic [BYTE_W-1:0] r8;
    logic [WORD_W-1:0] r16;
    logic              use16;
    logic [FLAGS_W-1:0] f;

    assign a      = item.operand_a[BYTE_W-1:0];
    assign b      = item.operand_b[BYTE_W-1:0];
    assign cin    = flags_in[FLAG_C];
    assign t      = cin & ((item.op == OP_ADC) | (item.op == OP_SBC));
    assign sum9    = {1'b0, a} + {1'b0, b} + {8'd0, t};
    assign nib_sum = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t};
    assign dif9    = {1'b0, a} - {1'b0, b} - {8'd0, t};
    assign nib_dif = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, t};
    assign inc8    = a + 8'd1;
    assign dec8    = a - 8'd1;
    assign sum17   = {1'b0, item.operand_a} + {1'b0, item.operand_b};
    assign sum13   = {1'b0, item.operand_a[11:0]} + {1'b0, item.operand_b[11:0]};
    assign b_sext  = {{BYTE_W{b[BYTE_W-1]}}, b};
    assign sp_c9   = {1'b0, item.operand_a[BYTE_W-1:0]} + {1'b0, b};
    assign sp_h5   = {1'b0, item.operand_a[3:0]} + {1'b0, b[3:0]};
    assign mask8   = 8'd1 << item.bit_index;
    assign lo_big  = a[3:0] > DAA_DIGIT_MAX;

    always_comb
    begin
        daa_r = a;
        daa_c = cin;
        if (flags_in[FLAG_N])
        begin
            daa_r = a - (flags_in[FLAG_H] ? DAA_ADJ_LO : 8'd0)
                      - (cin ? DAA_ADJ_HI : 8'd0);
        end
        else if (cin || (a > DAA_BCD_MAX))
        begin
            daa_r = a + ((flags_in[FLAG_H] || lo_big) ? DAA_ADJ_BOTH : DAA_ADJ_HI);
            daa_c = 1'b1;
        end
        else if (flags_in[FLAG_H] || lo_big)
        begin
            daa_r = a + DAA_ADJ_LO;
        end
    end

    always_comb
    begin
        r8    = '0;
        r16   = '0;
        use16 = 1'b0;
        f     = flags_in;
        unique case (item.op)
            OP_ADD, OP_ADC:
            begin
                r8 = sum9[BYTE_W-1:0];
                f  = {(r8 == 8'd0), 1'b0, nib_sum[4], sum9[BYTE_W]};
            end
            OP_SUB, OP_SBC:
            begin
                r8 = dif9[BYTE_W-1:0];
                f  = {(r8 == 8'd0), 1'b1, nib_dif[4], dif9[BYTE_W]};
            end
            OP_AND:
            begin
                r8 = a & b;
                f  = {(r8 == 8'd0), 1'b0, 1'b1, 1'b0};
            end
            OP_OR:
            begin
                r8 = a | b;
                f  = {(r8 == 8'd0), 3'b000};
            end
            OP_XOR:
            begin
                r8 = a ^ b;
                f  = {(r8 == 8'd0), 3'b000};
            end
            OP_INC:
            begin
                r8 = inc8;
                f  = {(r8 == 8'd0), 1'b0, (r8[3:0] == 4'h0), cin};
            end
            OP_DEC:
            begin
                r8 = dec8;
                f  = {(r8 == 8'd0), 1'b1, (r8[3:0] == 4'hF), cin};
            end
            OP_ADD16:
            begin
                use16 = 1'b1;
                r16   = sum17[WORD_W-1:0];
                f     = {flags_in[FLAG_Z], 1'b0, sum13[12], sum17[WORD_W]};
            end
            OP_ADDSP:
            begin
                use16 = 1'b1;
                r16   = item.operand_a + b_sext;
                f     = {2'b00, sp_h5[4], sp_c9[BYTE_W]};
            end
            OP_SWAP:
            begin
                r8 = {a[3:0], a[7:4]};
                f  = {(r8 == 8'd0), 3'b000};
            end
            OP_RL:
            begin
                r8 = {a[6:0], cin};
                f  = {(r8 == 8'd0), 2'b00, a[7]};
            end
            OP_RLC:
            begin
                r8 = {a[6:0], a[7]};
                f  = {(r8 == 8'd0), 2'b00, a[7]};
            end
            OP_RR:
            begin
                r8 = {cin, a[7:1]};
                f  = {(r8 == 8'd0), 2'b00, a[0]};
            end
            OP_RRC:
            begin
                r8 = {a[0], a[7:1]};
                f  = {(r8 == 8'd0), 2'b00, a[0]};
            end
            OP_SLA:
            begin
                r8 = {a[6:0], 1'b0};
                f  = {(r8 == 8'd0), 2'b00, a[7]};
            end
            OP_SRA:
            begin
                r8 = {a[7], a[7:1]};
                f  = {(r8 == 8'd0), 2'b00, a[0]};
            end
            OP_SRL:
            begin
                r8 = {1'b0, a[7:1]};
                f  = {(r8 == 8'd0), 2'b00, a[0]};
            end
            OP_BIT:
            begin
                f = {~a[item.bit_index], 1'b0, 1'b1, cin};
            end
            OP_SET:
            begin
                r8 = a | mask8;
            end
            OP_RES:
            begin
                r8 = a & ~mask8;
            end
            OP_DAA:
            begin
                r8 = daa_r;
                f  = {(r8 == 8'd0), flags_in[FLAG_N], 1'b0, daa_c};
            end
            default:
            begin
                r8 = '0;
            end
        endcase
    end

    assign res.result = use16 ? r16 : {8'd0, r8};
    assign res.flags  = f;

endmodule

[test/tb_cpu_alu_with_flags_unit.sv]
// ----------------------------------------------------------------------------
// tb_cpu_alu_with_flags_unit
// Self-checking bench for the flag-keeping 8-bit ALU. Operations go in over
// the s_* stream and results come back over m_*. Each input transfer runs
// through a local copy of the ALU and its Z/N/H/C register. The expected
// result and flags are queued, and every output transfer is checked against
// the oldest one. The stimulus covers corner operands and every opcode,
// including the unused codes. It also runs BCD add/sub chains that end in
// DAA, random traffic with idle bursts on both sides, and a long output
// stall that backs the pipeline up.
// ----------------------------------------------------------------------------
module tb_cpu_alu_with_flags_unit
    import calu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // op[4:0], operand_a[20:5], operand_b[36:21], bit_index[39:37]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // result[15:0], flags[19:16], zero[23:20]

    alu_res_t           pending_results[$];
    logic [FLAGS_W-1:0] flag_reg = FLAGS_RESET;
    logic [WORD_W-1:0]  last_result = '0;
    int                 mismatch_count = 0;
    int                 hold_cycles = 0;
    bit                 src_gaps_on = 1'b1;
    bit                 sink_gaps_on = 1'b1;

    logic [7:0] corner_bytes [10] = '{8'h00, 8'h01, 8'h0F, 8'h10, 8'h7F,
                                      8'h80, 8'h99, 8'h9A, 8'hF0, 8'hFF};

    cpu_alu_with_flags_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic alu_res_t compute_alu(alu_item_t it, logic [FLAGS_W-1:0] fl);
        alu_res_t    res;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  r8;
        logic [8:0]  s9;
        logic [4:0]  s5;
        logic [16:0] s17;
        logic [12:0] s13;
        logic        cin;
        logic        t;
        logic        c;
        a   = it.operand_a[7:0];
        b   = it.operand_b[7:0];
        cin = fl[FLAG_C];
        res.result = '0;
        res.flags  = fl;
        case (it.op)
            OP_ADD, OP_ADC:
            begin
                t  = (it.op == OP_ADC) ? cin : 1'b0;
                s9 = {1'b0, a} + {1'b0, b} + {8'd0, t};
                s5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t};
                res.result = {8'h00, s9[7:0]};
                res.flags  = {s9[7:0] == 8'h00, 1'b0, s5[4], s9[8]};
            end
            OP_SUB, OP_SBC:
            begin
                t  = (it.op == OP_SBC) ? cin : 1'b0;
                s9 = {1'b0, a} - {1'b0, b} - {8'd0, t};
                s5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, t};
                res.result = {8'h00, s9[7:0]};
                res.flags  = {s9[7:0] == 8'h00, 1'b1, s5[4], s9[8]};
            end
            OP_AND:
            begin
                r8 = a & b;
                res.result = {8'h00, r8};
                res.flags  = {r8 == 8'h00, 1'b0, 1'b1, 1'b0};
            end
            OP_OR:
            begin
                r8 = a | b;
                res.result = {8'h00, r8};
                res.flags  = {r8 == 8'h00, 3'b000};
            end
            OP_XOR:
            begin
                r8 = a ^ b;
                res.result = {8'h00, r8};
                res.flags  = {r8 == 8'h00, 3'b000};
            end
            OP_INC:
            begin
                r8 = a + 8'h01;
                res.result = {8'h00, r8};
                res.flags  = {r8 == 8'h00, 1'b0, r8[3:0] == 4'h0, cin};
            end
            OP_DEC:
            begin
                r8 = a - 8'h01;
                res.result = {8'h00, r8};
                res.flags  = {r8 == 8'h00, 1'b1, r8[3:0] == 4'hF, cin};
            end
            OP_ADD16:
            begin
                s17 = {1'b0, it.operand_a} + {1'b0, it.operand_b};
                s13 = {1'b0, it.operand_a[11:0]} + {1'b0, it.operand_b[11:0]};
                res.result = s17[15:0];
                res.flags  = {fl[FLAG_Z], 1'b0, s13[12], s17[16]};
            end
            OP_ADDSP:
            begin
                s5 = {1'b0, it.operand_a[3:0]} + {1'b0, b[3:0]};
                s9 = {1'b0, it.operand_a[7:0]} + {1'b0, b};
                res.result = it.operand_a + {{8{b[7]}}, b};
                res.flags  = {2'b00, s5[4], s9[8]};
            end
            OP_SWAP:
            begin
                r8 = {a[3:0], a[7:4]};
                res.result = {8'h00, r8};
                res.flags  = {r8 == 8'h00, 3'b000};
            end
            OP_RL, OP_RLC, OP_SLA:
            begin
                case (it.op)
                    OP_RL:   r8 = {a[6:0], cin};
                    OP_RLC:  r8 = {a[6:0], a[7]};
                    default: r8 = {a[6:0], 1'b0};
                endcase
                res.result = {8'h00, r8};
                res.flags  = {r8 == 8'h00, 2'b00, a[7]};
            end
            OP_RR, OP_RRC, OP_SRA, OP_SRL:
            begin
                case (it.op)
                    OP_RR:   r8 = {cin, a[7:1]};
                    OP_RRC:  r8 = {a[0], a[7:1]};
                    OP_SRA:  r8 = {a[7], a[7:1]};
                    default: r8 = {1'b0, a[7:1]};
                endcase
                res.result = {8'h00, r8};
                res.flags  = {r8 == 8'h00, 2'b00, a[0]};
            end
            OP_BIT:
            begin
                res.result = '0;
                res.flags  = {~a[it.bit_index], 1'b0, 1'b1, cin};
            end
            OP_SET:
            begin
                res.result = {8'h00, a | (8'h01 << it.bit_index)};
            end
            OP_RES:
            begin
                res.result = {8'h00, a & ~(8'h01 << it.bit_index)};
            end
            OP_DAA:
            begin
                r8 = a;
                c  = fl[FLAG_C];
                if (fl[FLAG_N])
                begin
                    if (fl[FLAG_H])
                        r8 = r8 - DAA_ADJ_LO;
                    if (fl[FLAG_C])
                        r8 = r8 - DAA_ADJ_HI;
                end
                else if (fl[FLAG_C] || a > DAA_BCD_MAX)
                begin
                    r8 = r8 + ((fl[FLAG_H] || a[3:0] > DAA_DIGIT_MAX) ? DAA_ADJ_BOTH
                                                                     : DAA_ADJ_HI);
                    c  = 1'b1;
                end
                else if (fl[FLAG_H] || a[3:0] > DAA_DIGIT_MAX)
                begin
                    r8 = r8 + DAA_ADJ_LO;
                end
                res.result = {8'h00, r8};
                res.flags  = {r8 == 8'h00, fl[FLAG_N], 1'b0, c};
            end
            default:
            begin
                res.result = '0;
            end
        endcase
        return res;
    endfunction

    task automatic send_op(logic [OP_W-1:0] op, logic [WORD_W-1:0] a,
                           logic [WORD_W-1:0] b, logic [BIDX_W-1:0] bi);
        alu_item_t it;
        alu_res_t  want;
        it.op        = op;
        it.operand_a = a;
        it.operand_b = b;
        it.bit_index = bi;
        if (src_gaps_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        want = compute_alu(it, flag_reg);
        flag_reg    = want.flags;
        last_result = want.result;
        pending_results.push_back(want);
        @(posedge clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return {8'($urandom), corner_bytes[4'($urandom_range(0, 9))]};
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        if ($urandom_range(0, 15) == 0)
            return OP_W'($urandom_range(23, 31));
        return OP_W'($urandom_range(OP_ADD, OP_DAA));
    endfunction

    function automatic logic [WORD_W-1:0] pick_bcd();
        return {8'($urandom), 4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    endfunction

    task automatic test_directed();
        send_op(OP_DAA,   16'h0000, 16'h0000, 3'd0);
        send_op(OP_ADD,   16'hABFF, 16'hCD01, 3'd0);
        send_op(OP_ADC,   16'h000F, 16'hFF00, 3'd0);
        send_op(OP_SUB,   16'hFF00, 16'h0001, 3'd0);
        send_op(OP_SBC,   16'h0010, 16'h000F, 3'd0);
        send_op(OP_DAA,   16'h0001, 16'h0000, 3'd0);
        send_op(OP_AND,   16'h00F0, 16'hFF0F, 3'd0);
        send_op(OP_OR,    16'hFF00, 16'hFF00, 3'd0);
        send_op(OP_XOR,   16'h12FF, 16'h34FF, 3'd0);
        send_op(OP_INC,   16'h00FF, 16'h0000, 3'd0);
        send_op(OP_DEC,   16'hFF00, 16'h0000, 3'd0);
        send_op(OP_ADD16, 16'hFFFF, 16'h0001, 3'd0);
        send_op(OP_ADDSP, 16'hFFFF, 16'hFF80, 3'd0);
        send_op(OP_SWAP,  16'h00A5, 16'h0000, 3'd0);
        send_op(OP_RL,    16'h0080, 16'h0000, 3'd0);
        send_op(OP_RLC,   16'h0080, 16'h0000, 3'd0);
        send_op(OP_RR,    16'h0001, 16'h0000, 3'd0);
        send_op(OP_RRC,   16'h0001, 16'h0000, 3'd0);
        send_op(OP_SLA,   16'h00FF, 16'h0000, 3'd0);
        send_op(OP_SRA,   16'h0081, 16'h0000, 3'd0);
        send_op(OP_SRL,   16'h0001, 16'h0000, 3'd0);
        send_op(OP_BIT,   16'h007F, 16'h0000, 3'd7);
        send_op(OP_SET,   16'hFF00, 16'hFFFF, 3'd7);
        send_op(OP_RES,   16'h00FF, 16'h0000, 3'd0);
        send_op(5'd23,    16'hFFFF, 16'hFFFF, 3'd7);
        send_op(5'd31,    16'h1234, 16'h5678, 3'd3);
    endtask

    task automatic test_random_ops(int count);
        repeat (count)
            send_op(pick_op(), pick_word(), pick_word(), BIDX_W'($urandom_range(0, 7)));
    endtask

    task automatic test_bcd_chains(int count);
        logic [OP_W-1:0] op;
        repeat (count)
        begin
            case ($urandom_range(0, 3))
                0:       op = OP_ADD;
                1:       op = OP_ADC;
                2:       op = OP_SUB;
                default: op = OP_SBC;
            endcase
            send_op(op, pick_bcd(), pick_bcd(), BIDX_W'($urandom));
            send_op(OP_DAA, {8'($urandom), last_result[7:0]}, 16'($urandom),
                    BIDX_W'($urandom));
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 80;
        src_gaps_on = 1'b0;
        test_random_ops(30);
        src_gaps_on = 1'b1;
    endtask

    task automatic test_steady_stream(int count);
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b0;
        test_random_ops(count / 2);
        test_bcd_chains(count / 4);
    endtask

    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (sink_gaps_on && $urandom_range(0, 5) == 0)
            begin
                m_tready   <= 1'b0;
                stall_left = $urandom_range(0, 17);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(negedge clk)
    begin : result_check
        alu_res_t got;
        alu_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[19:0];
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer: result %h flags %b",
                       got.result, got.flags);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.result !== want.result)
                begin
                    $error("result: expected %h, got %h", want.result, got.result);
                    mismatch_count++;
                end
                if (got.flags !== want.flags)
                begin
                    $error("flags: expected %b, got %b", want.flags, got.flags);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_ops(650);
        test_bcd_chains(200);
        test_backpressure();
        test_steady_stream(600);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
